>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define L4CV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, written as antecedent and consequent in the same cycle.
`define L4CV_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	`L4CV_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

>>> hdl/l4cv_pkg.sv
// Constants, types and the ones'-complement add for the L4 checksum verifier.
// No dependencies.
package l4cv_pkg;

	localparam logic [15:0] LINK_HEADER_BYTES = 16'd14;
	localparam logic [15:0] NET_HEADER_BYTES  = 16'd20;
	localparam logic [15:0] POS_LIMIT         = 16'hFFFF;

	// IPv4 header byte offsets
	localparam logic [15:0] IP_LEN_HI  = 16'd2;
	localparam logic [15:0] IP_LEN_LO  = 16'd3;
	localparam logic [15:0] IP_PROTO   = 16'd9;
	localparam logic [15:0] ADDR_START = 16'd12;

	localparam logic [7:0] PROTO_UDP = 8'h11;
	localparam logic [7:0] PROTO_TCP = 8'h06;

	// Segment header layout
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] TCP_HDR_BYTES = 16'd20;
	localparam logic [15:0] UDP_CK_OFFSET = 16'd6;
	localparam logic [15:0] TCP_CK_OFFSET = 16'd16;
	localparam logic [15:0] UDP_LEN_HI    = 16'd4;
	localparam logic [15:0] UDP_LEN_LO    = 16'd5;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_UDP   = 2'd1,
		KIND_TCP   = 2'd2
	} kind_t;

	// 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

>>> hdl/l4cv_if.sv
// Request channels of the L4 checksum verifier: frame bytes in, verdicts out.
// No dependencies.
interface l4cv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, data_byte, last, input ready);
	modport sink (input valid, data_byte, last, output ready);
endinterface

interface l4cv_verdict_if;
	logic        valid;
	logic        ready;
	logic [1:0]  protocol_kind;
	logic        checksum_ok;
	logic [15:0] computed_checksum;
	logic [15:0] received_checksum;
	logic        truncated;

	modport source (output valid, protocol_kind, checksum_ok, computed_checksum,
		received_checksum, truncated, input ready);
	modport sink (input valid, protocol_kind, checksum_ok, computed_checksum,
		received_checksum, truncated, output ready);
endinterface

>>> hdl/l4_checksum_verifier_top.sv
// channel       dir  request               payload
// frame_bytes   in   one frame byte        data_byte[7:0], last
// verdict       out  one result per frame  protocol_kind, checksum_ok, checksums, truncated
//
// One byte per cycle, a stalled last byte apart: input register, one pass of header decode and
// up to two chained 16-bit end-around-carry adds, then the verdict register.
// The last byte of a frame goes from the input register into the verdict register.
// Async reset clears all frame state and empties both registers.
// A last byte waits in the input register while a verdict is still held; others never wait there.
// Depends on l4cv_pkg and l4cv_if.
module l4_checksum_verifier_top
	import l4cv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	l4cv_byte_if.sink       frame_bytes,
	l4cv_verdict_if.source  verdict
);

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// frame state
	logic [15:0] pos_q;
	logic [15:0] sum_q;
	logic [7:0]  held_q;
	kind_t       kind_q;
	logic [15:0] iplen_q;
	logic [15:0] seglen_q;
	logic [15:0] ck_q;

	logic [15:0] pos_n, sum_n, iplen_n, seglen_n, ck_n;
	logic [7:0]  held_n;
	kind_t       kind_n;

	// verdict register
	logic        ov_q;
	logic [1:0]  kind_out_q;
	logic        ok_q;
	logic [15:0] comp_q;
	logic [15:0] recv_q;
	logic        trunc_q;

	logic        res_free, fire_s1, done_s1;
	logic [15:0] ipo, seg_o, tcp_seg, seg_v, limit, hdr, ck_off, hdr_n, seg_need;
	logic        pos_ok, in_link, in_net, is_udp;
	logic [16:0] need;
	logic [15:0] comp_n, recv_n;

	assign res_free = !ov_q || verdict.ready;
	assign fire_s1  = valid_s1 && (!last_s1 || res_free);
	assign done_s1  = fire_s1 && last_s1;
	assign frame_bytes.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_bytes.ready) begin
			valid_s1 <= frame_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_bytes.ready && frame_bytes.valid) begin
			data_s1 <= frame_bytes.data_byte;
			last_s1 <= frame_bytes.last;
		end
	end

	assign pos_ok  = pos_q != POS_LIMIT;
	assign ipo     = pos_q - LINK_HEADER_BYTES;
	assign seg_o   = ipo - NET_HEADER_BYTES;
	assign in_link = pos_q < LINK_HEADER_BYTES;
	assign in_net  = ipo < NET_HEADER_BYTES;
	assign is_udp  = kind_q == KIND_UDP;
	assign hdr     = is_udp ? UDP_HDR_BYTES : TCP_HDR_BYTES;
	assign ck_off  = is_udp ? UDP_CK_OFFSET : TCP_CK_OFFSET;
	assign tcp_seg = (iplen_q >= NET_HEADER_BYTES) ? iplen_q - NET_HEADER_BYTES : 16'd0;

	// UDP length field lands in this same byte, so the limit sees the new value
	always_comb begin
		seg_v = seglen_q;
		if (is_udp && seg_o == UDP_LEN_HI) begin
			seg_v = {data_s1, 8'h00};
		end else if (is_udp && seg_o == UDP_LEN_LO) begin
			seg_v = seglen_q | {8'h00, data_s1};
		end
	end
	assign limit = (seg_v > hdr) ? seg_v : hdr;

	always_comb begin
		pos_n    = pos_ok ? pos_q + 16'd1 : pos_q;
		sum_n    = sum_q;
		held_n   = held_q;
		kind_n   = kind_q;
		iplen_n  = iplen_q;
		seglen_n = seglen_q;
		ck_n     = ck_q;
		if (pos_ok && !in_link) begin
			if (in_net) begin
				if (ipo == IP_LEN_HI) begin
					iplen_n = {data_s1, 8'h00};
				end else if (ipo == IP_LEN_LO) begin
					iplen_n = iplen_q | {8'h00, data_s1};
				end else if (ipo == IP_PROTO) begin
					if (data_s1 == PROTO_UDP) begin
						kind_n = KIND_UDP;
						sum_n  = oc_add(sum_q, {8'h00, PROTO_UDP});
					end else if (data_s1 == PROTO_TCP) begin
						kind_n   = KIND_TCP;
						seglen_n = tcp_seg;
						sum_n    = oc_add(oc_add(sum_q, {8'h00, PROTO_TCP}), tcp_seg);
					end else begin
						kind_n = KIND_OTHER;
					end
				end else if (ipo >= ADDR_START) begin
					if (!ipo[0]) begin
						held_n = data_s1;
						if (last_s1) begin
							sum_n = oc_add(sum_q, {data_s1, 8'h00});
						end
					end else begin
						sum_n = oc_add(sum_q, {held_q, data_s1});
					end
				end
			end else if (kind_q != KIND_OTHER) begin
				if (is_udp && (seg_o == UDP_LEN_HI || seg_o == UDP_LEN_LO)) begin
					seglen_n = seg_v;
				end
				// length joins the pseudo-header sum once complete
				if (is_udp && seg_o == UDP_LEN_LO) begin
					sum_n = oc_add(sum_q, seg_v);
				end
				if (seg_o == ck_off) begin
					ck_n = {data_s1, 8'h00};
				end else if (seg_o == ck_off + 16'd1) begin
					ck_n = ck_q | {8'h00, data_s1};
				end else if (!seg_o[0]) begin
					if (seg_o < limit) begin
						held_n = data_s1;
						if (last_s1) begin
							sum_n = oc_add(sum_n, {data_s1, 8'h00});
						end
					end
				end else begin
					if (seg_o < limit) begin
						sum_n = oc_add(sum_n, {held_q, data_s1});
					end else if (seg_o - 16'd1 < limit) begin
						// odd segment length: pad the held byte
						sum_n = oc_add(sum_n, {held_q, 8'h00});
					end
				end
			end
		end
	end

	// verdict from the updated state
	assign hdr_n    = (kind_n == KIND_UDP) ? UDP_HDR_BYTES : TCP_HDR_BYTES;
	assign seg_need = (seglen_n > hdr_n) ? seglen_n : hdr_n;
	assign need     = {1'b0, LINK_HEADER_BYTES} + {1'b0, NET_HEADER_BYTES}
		+ ((kind_n == KIND_OTHER) ? 17'd0 : {1'b0, seg_need});
	assign comp_n   = (kind_n == KIND_OTHER) ? 16'd0 : ~sum_n;
	assign recv_n   = (kind_n == KIND_OTHER) ? 16'd0 : ck_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			held_q   <= '0;
			kind_q   <= KIND_OTHER;
			iplen_q  <= '0;
			seglen_q <= '0;
			ck_q     <= '0;
		end else if (done_s1) begin
			pos_q    <= '0;
			sum_q    <= '0;
			held_q   <= '0;
			kind_q   <= KIND_OTHER;
			iplen_q  <= '0;
			seglen_q <= '0;
			ck_q     <= '0;
		end else if (fire_s1) begin
			pos_q    <= pos_n;
			sum_q    <= sum_n;
			held_q   <= held_n;
			kind_q   <= kind_n;
			iplen_q  <= iplen_n;
			seglen_q <= seglen_n;
			ck_q     <= ck_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (done_s1) begin
			ov_q <= 1'b1;
		end else if (verdict.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			kind_out_q <= kind_n;
			ok_q       <= (kind_n == KIND_OTHER) || (comp_n == recv_n);
			comp_q     <= comp_n;
			recv_q     <= recv_n;
			trunc_q    <= {1'b0, pos_n} < need;
		end
	end

	assign verdict.valid             = ov_q;
	assign verdict.protocol_kind     = kind_out_q;
	assign verdict.checksum_ok       = ok_q;
	assign verdict.computed_checksum = comp_q;
	assign verdict.received_checksum = recv_q;
	assign verdict.truncated         = trunc_q;

endmodule

>>> hdl/l4cv_checker.sv
// Port-level checks on the verifier's verdict channel, bound to the top level.
// Depends on l4cv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module l4cv_checker
	import l4cv_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  protocol_kind,
	input logic        checksum_ok,
	input logic [15:0] computed_checksum,
	input logic [15:0] received_checksum,
	input logic        truncated
);

	logic        stalled;
	logic        other_v;
	logic        chk_v;
	logic        other_clean;
	logic        ok_consistent;
	logic [35:0] payload;

	assign stalled       = rsp_valid && !rsp_ready;
	assign other_v       = rsp_valid && protocol_kind == KIND_OTHER;
	assign chk_v         = rsp_valid && protocol_kind != KIND_OTHER;
	assign other_clean   = checksum_ok && computed_checksum == 16'd0
		&& received_checksum == 16'd0;
	assign ok_consistent = checksum_ok == (computed_checksum == received_checksum);
	assign payload       = {protocol_kind, checksum_ok, computed_checksum,
		received_checksum, truncated};

	// non-checksummed frames report zeros and always pass
	`L4CV_IMPLY(a_other_pass, clk, arst_n, other_v, other_clean, "other verdict not clean")
	`L4CV_IMPLY(a_ok_matches, clk, arst_n, chk_v, ok_consistent, "checksum_ok disagrees")
	`L4CV_ASSERT(a_valid_holds, clk, arst_n, stalled |=> rsp_valid, "verdict dropped while stalled")
	`L4CV_ASSERT(a_payload_holds, clk, arst_n, stalled |=> $stable(payload), "verdict changed")

endmodule

bind l4_checksum_verifier_top l4cv_checker u_l4cv_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (verdict.valid),
	.rsp_ready         (verdict.ready),
	.protocol_kind     (verdict.protocol_kind),
	.checksum_ok       (verdict.checksum_ok),
	.computed_checksum (verdict.computed_checksum),
	.received_checksum (verdict.received_checksum),
	.truncated         (verdict.truncated)
);
